FILE: src/trial_division_prime_test_defines.svh
// ----------------------------------------------------------------------------
// trial division prime test: assertion macros
// concurrent checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tdp check failed");
`define TDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tdp check failed");
`else
`define TDP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TDP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg
// shared types and constants of the trial division prime test
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FIRST_DIVISOR   = 3;
  localparam int unsigned DIVISOR_STEP    = 2;
  localparam int unsigned SMALLEST_PRIME  = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } tdp_state_e;

  // status of one serial division, valid while done is high
  typedef struct packed {
    logic done;
    logic rem_zero;
    logic bound_hit;
  } div_status_t;

endpackage

FILE: src/tdp_serial_div.sv
// ----------------------------------------------------------------------------
// tdp_serial_div
// bit-serial restoring divider, one dividend bit per cycle
// ----------------------------------------------------------------------------
module tdp_serial_div import tdp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned DIV_WIDTH   = (VALUE_WIDTH - 1) / 2 + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [DIV_WIDTH-1:0]   divisor_i,
  output div_status_t            status_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] num_q, num_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [DIV_WIDTH-1:0]   rem_q, rem_d;

  logic [DIV_WIDTH:0]     trial;
  logic [DIV_WIDTH:0]     diff;
  logic                   ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, num_q[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = value_i;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[VALUE_WIDTH-2:0], 1'b0};
      quo_d = {quo_q[VALUE_WIDTH-2:0], ge};
      rem_d = ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      cnt_d = cnt_q + CntWidth'(1);
      if (cnt_q == CntWidth'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // divisor above the quotient means divisor squared exceeds the value
  always_comb begin
    status_o.done      = done_q;
    status_o.rem_zero  = rem_q == '0;
    status_o.bound_hit = VALUE_WIDTH'(divisor_i) > quo_q;
  end

endmodule

FILE: src/trial_division_prime_test.sv
// Negative, small or even candidates go straight from ST_IDLE to ST_DONE; otherwise
// each of k odd trial divisors passes through ST_START and ST_WAIT, k up to sqrt(n)/2.
// Worst case at 32 bits is about 23170 divisors.
// The bit-serial divider (one bit per cycle) sets the rate; one item at a time.
// A new item is taken while a finished result still waits in the output register.
// Reset (rst_ni, async, active low) empties the output register and idles the block.
`include "trial_division_prime_test_defines.svh"
// ----------------------------------------------------------------------------
// trial_division_prime_test
// primality of a signed integer by trial division with odd divisors
// ----------------------------------------------------------------------------
module trial_division_prime_test import tdp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] candidate_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   is_prime_o
);

  localparam int unsigned DivWidth = (VALUE_WIDTH - 1) / 2 + 2;

  tdp_state_e             state_q, state_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic [DivWidth-1:0]    divisor_q, divisor_d;
  logic                   result_q, result_d;
  logic                   out_valid_q, out_prime_q;
  logic                   out_load;
  logic                   div_start;
  div_status_t            div_status;

  logic                   cand_neg, cand_below2, cand_two, cand_even;

  assign cand_neg    = candidate_i[VALUE_WIDTH-1];
  assign cand_below2 = candidate_i[VALUE_WIDTH-1:1] == '0;
  assign cand_two    = candidate_i == VALUE_WIDTH'(SMALLEST_PRIME);
  assign cand_even   = !candidate_i[0];

  tdp_serial_div #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIV_WIDTH  (DivWidth)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .value_i  (value_q),
    .divisor_i(divisor_q),
    .status_o (div_status)
  );

  always_comb begin
    state_d    = state_q;
    value_d    = value_q;
    divisor_d  = divisor_q;
    result_d   = result_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          value_d = candidate_i;
          if (cand_neg || cand_below2 || cand_two || cand_even) begin
            result_d = cand_two;
            state_d  = ST_DONE;
          end else begin
            divisor_d = DivWidth'(FIRST_DIVISOR);
            state_d   = ST_START;
          end
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_status.done) begin
          if (div_status.bound_hit) begin
            result_d = 1'b1;
            state_d  = ST_DONE;
          end else if (div_status.rem_zero) begin
            result_d = 1'b0;
            state_d  = ST_DONE;
          end else begin
            divisor_d = divisor_q + DivWidth'(DIVISOR_STEP);
            state_d   = ST_START;
          end
        end
      end
      ST_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    divisor_q <= divisor_d;
    result_q  <= result_d;
    if (out_load) begin
      out_prime_q <= result_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_prime_q;

  `TDP_ASSERT_IMPL(a_done_only_in_wait, clk_i, rst_ni, div_status.done, state_q == ST_WAIT)
  `TDP_ASSERT_IMPL(a_divisor_odd, clk_i, rst_ni, state_q == ST_WAIT,
                   divisor_q[0] && (divisor_q != DivWidth'(1)))
  `TDP_ASSERT_IMPL(a_prime_odd_or_two, clk_i, rst_ni, state_q == ST_DONE && result_q,
                   value_q[0] || (value_q == VALUE_WIDTH'(SMALLEST_PRIME)))
  `TDP_ASSERT_NEXT(a_load_sets_valid, clk_i, rst_ni, out_load, out_valid_o)

endmodule

FILE: tb/trial_division_prime_test_tb.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_tb
// feeds signed candidates through the valid/ready input with random gaps,
// predicts each verdict by odd trial division and checks every output transfer
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;
  import tdp_pkg::*;

  localparam int unsigned W             = VALUE_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS  = 100;
  localparam int unsigned IDLE_PERCENT  = 36;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned SETTLE_CYCLES = 16;
  // the largest positive prime needs about 23000 divisions
  localparam int unsigned STALL_LIMIT   = 4_000_000;

  localparam logic [W-1:0] CORNER_VALUES [20] = '{
    32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5,
    32'd9, 32'd15, 32'd25, 32'd49,
    32'd63001, 32'd65521, 32'd65535,
    32'h5555_5555, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFF
  };

  class prime_verdict_board;
    typedef struct {
      logic [W-1:0] value;
      bit           prime;
    } verdict_t;

    verdict_t    verdict_q[$];
    int unsigned fault_count;

    function new();
      fault_count = 0;
    endfunction

    static function bit predict_prime(logic [W-1:0] value);
      longint unsigned n;
      longint unsigned d;
      if (value[W-1]) return 1'b0;
      n = value;
      if (n < SMALLEST_PRIME) return 1'b0;
      if (n == SMALLEST_PRIME) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      // d <= n / d keeps the bound free of any product
      for (d = FIRST_DIVISOR; d <= n / d; d += DIVISOR_STEP) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(logic [W-1:0] value);
      verdict_t entry;
      entry.value = value;
      entry.prime = predict_prime(value);
      verdict_q.push_back(entry);
    endfunction

    function void check_verdict(logic actual);
      verdict_t entry;
      if (verdict_q.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("verdict %0b with no candidate outstanding", actual);
        return;
      end
      entry = verdict_q.pop_front();
      if (actual !== entry.prime) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("candidate %0d (0x%h): expected is_prime %0b, got %0b",
                   $signed(entry.value), entry.value, entry.prime, actual);
      end
    endfunction

    function int unsigned outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_ready_o;
  logic [W-1:0] candidate_i;
  logic         out_valid_o;
  logic         out_ready_i;
  logic         is_prime_o;

  prime_verdict_board board;
  bit                 no_gaps;
  int unsigned        quiet_cycles;

  trial_division_prime_test #(
    .VALUE_WIDTH(W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_prime_o (is_prime_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly small or quickly settled values; wide values are negative, even
  // or carry a small odd factor so that no random item takes long
  function automatic logic [W-1:0] pick_candidate();
    int unsigned  roll;
    int unsigned  factor;
    int unsigned  span;
    logic [W-1:0] value;
    roll = $urandom_range(99);
    if (roll < 30) begin
      value = $urandom_range(4095);
    end else if (roll < 40) begin
      value = $urandom_range(65535);
    end else if (roll < 55) begin
      value = $urandom;
      value[W-1] = 1'b1;
    end else if (roll < 70) begin
      value = $urandom;
      value[0] = 1'b0;
    end else if (roll < 85) begin
      factor = 2 * $urandom_range(1, 6) + 1;
      span   = 32'h7FFF_FFFF / factor;
      value  = factor * (2 * $urandom_range((span - 1) / 2) + 1);
    end else begin
      value = $urandom_range(32'h000F_FFFF);
      value[0] = 1'b1;
    end
    return value;
  endfunction

  task automatic send_candidate(input logic [W-1:0] value);
    while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_candidate(value);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_verdict(is_prime_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_valid_i   = 1'b0;
    candidate_i  = '0;
    out_ready_i  = 1'b0;
    rst_ni       = 1'b0;
    no_gaps      = 1'b0;
    quiet_cycles = 0;
    board        = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (CORNER_VALUES[i]) send_candidate(CORNER_VALUES[i]);
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // back-to-back transfers on both sides for a stretch
      no_gaps = (i >= 40 && i < 60);
      send_candidate(pick_candidate());
    end
    no_gaps = 1'b0;
    in_valid_i <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/tdp_pkg.sv
src/tdp_serial_div.sv
src/trial_division_prime_test.sv
tb/trial_division_prime_test_tb.sv
